// ===== rtl/dcfr_pkg.sv =====
// Shared constants and field widths for the delimited command frame receiver.
package dcfr_pkg;

   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int LEN_W       = 6;
   localparam int RSP_DATA_W  = 16;
   localparam int RSP_USER_W  = 3;

   localparam int COMMAND_CAPACITY_DEF   = 62;
   localparam int PARAMETER_CAPACITY_DEF = 30;

   localparam logic [BYTE_W-1:0] BYTE_CMD_OPEN  = 8'h28;
   localparam logic [BYTE_W-1:0] BYTE_CMD_CLOSE = 8'h29;
   localparam logic [BYTE_W-1:0] BYTE_PAR_OPEN  = 8'h3C;
   localparam logic [BYTE_W-1:0] BYTE_PAR_CLOSE = 8'h3E;
   localparam logic [BYTE_W-1:0] BYTE_FORWARD   = 8'hEE;

   localparam logic [KIND_W-1:0] KIND_CMD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FWD = 2'd2;

   // Address width of a store of the given depth (at least one bit).
   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// ===== rtl/delimited_command_frame_receiver.sv =====
// A forwarded byte or an empty-frame word shows on rsp in the cycle after its byte is taken.
// A closer's words go through the store's read register, then rsp; they follow one per cycle while rsp keeps up.
// Throughput: one byte per cycle while rsp keeps up; a word left waiting on rsp holds req off.
// A closer with stored bytes holds req off until its frame store has been read out
// (one RAM read port per store).
// Reset (synchronous, active high): mode idle, both counts zero, forward_enable set, rsp empty.
// Store contents are not cleared; only entries below the fill count are ever read.
module delimited_command_frame_receiver
   #(
   parameter int COMMAND_CAPACITY   = dcfr_pkg::COMMAND_CAPACITY_DEF,
   parameter int PARAMETER_CAPACITY = dcfr_pkg::PARAMETER_CAPACITY_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // config register
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,   // forward_enable
   // input byte stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dcfr_pkg::BYTE_W-1:0]     req_tdata,     // [7:0] rx_byte
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dcfr_pkg::RSP_DATA_W-1:0] rsp_tdata,     // [7:0] data_byte, [13:8] frame_length, [15:14] zero
   output logic [dcfr_pkg::RSP_USER_W-1:0] rsp_tuser,     // [1:0] kind, [2] empty_frame
   output logic                            rsp_tlast      // last
);
   import dcfr_pkg::*;

   localparam int CMD_AW = addr_width(COMMAND_CAPACITY);
   localparam int PAR_AW = addr_width(PARAMETER_CAPACITY);
   localparam int CMD_CW = $clog2(COMMAND_CAPACITY + 1);
   localparam int PAR_CW = $clog2(PARAMETER_CAPACITY + 1);

   // receive mode
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_CMD  = 2'd1;
   localparam logic [1:0] MODE_PAR  = 2'd2;
   localparam logic [1:0] MODE_FWD  = 2'd3;

   // sequencer state
   localparam logic ST_RUN   = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic              fwd_en_ff, fwd_en_in;
   logic [1:0]        mode_ff, mode_in;
   logic              st_ff, st_in;
   logic [CMD_CW-1:0] cmd_cnt_ff, cmd_cnt_in;
   logic [PAR_CW-1:0] par_cnt_ff, par_cnt_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  drn_len_ff, drn_len_in;
   logic              drn_par_ff, drn_par_in;

   // output register
   logic              rsp_vld_ff, rsp_vld_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_last_ff, rsp_last_in;

   // store ports
   logic              cmd_we, par_we, cmd_re, par_re;
   logic [LEN_W-1:0]  rd_idx;
   logic [BYTE_W-1:0] cmd_rdata, par_rdata, drn_rdata;

   logic              out_free, req_acc;
   logic [BYTE_W-1:0] rx_byte;
   logic              drn_last;

   assign rx_byte    = req_tdata;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   // take no byte while draining; stores are never written and read in one cycle
   assign req_tready = (st_ff == ST_RUN) && out_free;
   assign req_acc    = req_tvalid && req_tready;
   assign drn_rdata  = drn_par_ff ? par_rdata : cmd_rdata;
   assign drn_last   = (LEN_W'(idx_ff + 1'b1) == drn_len_ff);

   always_comb begin
      fwd_en_in    = csr_wr_en ? csr_wr_data : fwd_en_ff;
      mode_in      = mode_ff;
      st_in        = st_ff;
      cmd_cnt_in   = cmd_cnt_ff;
      par_cnt_in   = par_cnt_ff;
      idx_in       = idx_ff;
      drn_len_in   = drn_len_ff;
      drn_par_in   = drn_par_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      cmd_we       = 1'b0;
      par_we       = 1'b0;
      cmd_re       = 1'b0;
      par_re       = 1'b0;
      rd_idx       = '0;

      unique case (st_ff)
         ST_RUN: begin
            if (req_acc) begin
               if (rx_byte == BYTE_CMD_OPEN) begin
                  mode_in    = MODE_CMD;
                  cmd_cnt_in = '0;
               end else if (rx_byte == BYTE_PAR_OPEN) begin
                  mode_in    = MODE_PAR;
                  par_cnt_in = '0;
               end else if (rx_byte == BYTE_FORWARD && fwd_en_ff) begin
                  mode_in = MODE_FWD;
               end else begin
                  unique case (mode_ff)
                     MODE_CMD: begin
                        if (rx_byte == BYTE_CMD_CLOSE) begin
                           mode_in = MODE_IDLE;
                           if (cmd_cnt_ff == '0) begin
                              // empty frame: one flagged word
                              rsp_vld_in   = 1'b1;
                              rsp_kind_in  = KIND_CMD;
                              rsp_byte_in  = '0;
                              rsp_len_in   = '0;
                              rsp_empty_in = 1'b1;
                              rsp_last_in  = 1'b1;
                           end else begin
                              // start readout at entry zero
                              st_in      = ST_DRAIN;
                              idx_in     = '0;
                              drn_len_in = LEN_W'(cmd_cnt_ff);
                              drn_par_in = 1'b0;
                              cmd_re     = 1'b1;
                           end
                        end else if (cmd_cnt_ff < CMD_CW'(COMMAND_CAPACITY)) begin
                           cmd_we     = 1'b1;
                           cmd_cnt_in = cmd_cnt_ff + 1'b1;
                        end
                     end
                     MODE_PAR: begin
                        if (rx_byte == BYTE_PAR_CLOSE) begin
                           mode_in = MODE_IDLE;
                           if (par_cnt_ff == '0) begin
                              rsp_vld_in   = 1'b1;
                              rsp_kind_in  = KIND_PAR;
                              rsp_byte_in  = '0;
                              rsp_len_in   = '0;
                              rsp_empty_in = 1'b1;
                              rsp_last_in  = 1'b1;
                           end else begin
                              st_in      = ST_DRAIN;
                              idx_in     = '0;
                              drn_len_in = LEN_W'(par_cnt_ff);
                              drn_par_in = 1'b1;
                              par_re     = 1'b1;
                           end
                        end else if (par_cnt_ff < PAR_CW'(PARAMETER_CAPACITY)) begin
                           par_we     = 1'b1;
                           par_cnt_in = par_cnt_ff + 1'b1;
                        end
                     end
                     MODE_FWD: begin
                        // pass the byte straight through
                        rsp_vld_in   = 1'b1;
                        rsp_kind_in  = KIND_FWD;
                        rsp_byte_in  = rx_byte;
                        rsp_len_in   = '0;
                        rsp_empty_in = 1'b0;
                        rsp_last_in  = 1'b1;
                     end
                     default: begin
                        // idle: drop stray bytes
                     end
                  endcase
               end
            end
         end
         ST_DRAIN: begin
            // RAM data for idx_ff is waiting; move it out when the output slot frees up
            if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_kind_in  = drn_par_ff ? KIND_PAR : KIND_CMD;
               rsp_byte_in  = drn_rdata;
               rsp_len_in   = drn_len_ff;
               rsp_empty_in = 1'b0;
               rsp_last_in  = drn_last;
               if (drn_last) begin
                  st_in = ST_RUN;
               end else begin
                  idx_in = LEN_W'(idx_ff + 1'b1);
                  rd_idx = idx_in;
                  cmd_re = !drn_par_ff;
                  par_re = drn_par_ff;
               end
            end
         end
         default: begin
            st_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_en_ff  <= 1'b1;
         mode_ff    <= MODE_IDLE;
         st_ff      <= ST_RUN;
         cmd_cnt_ff <= '0;
         par_cnt_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         fwd_en_ff  <= fwd_en_in;
         mode_ff    <= mode_in;
         st_ff      <= st_in;
         cmd_cnt_ff <= cmd_cnt_in;
         par_cnt_ff <= par_cnt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      drn_len_ff   <= drn_len_in;
      drn_par_ff   <= drn_par_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   dcfr_ram #(
      .WIDTH  (BYTE_W),
      .DEPTH  (COMMAND_CAPACITY),
      .ADDR_W (CMD_AW)
   ) u_cmd_store (
      .clock   (clock),
      .wr_en   (cmd_we),
      .wr_addr (cmd_cnt_ff[CMD_AW-1:0]),
      .wr_data (rx_byte),
      .rd_en   (cmd_re),
      .rd_addr (rd_idx[CMD_AW-1:0]),
      .rd_data (cmd_rdata)
   );

   dcfr_ram #(
      .WIDTH  (BYTE_W),
      .DEPTH  (PARAMETER_CAPACITY),
      .ADDR_W (PAR_AW)
   ) u_par_store (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_cnt_ff[PAR_AW-1:0]),
      .wr_data (rx_byte),
      .rd_en   (par_re),
      .rd_addr (rd_idx[PAR_AW-1:0]),
      .rd_data (par_rdata)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {2'b00, rsp_len_ff, rsp_byte_ff};
   assign rsp_tuser  = {rsp_empty_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // a frame word taken without last is followed at once by the next word of the run
   a_drain_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast && rsp_kind_ff != KIND_FWD
      |=> rsp_tvalid)
      else $error("frame readout stopped before its last word");

   // fill counts stay within the stores
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cmd_cnt_ff <= CMD_CW'(COMMAND_CAPACITY) && par_cnt_ff <= PAR_CW'(PARAMETER_CAPACITY))
      else $error("store fill count beyond capacity");

   // a non-empty frame word carries a nonzero length, a forwarded word none
   a_len_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_kind_ff == KIND_FWD) ? (rsp_len_ff == '0)
                                                : ((rsp_len_ff == '0) == rsp_empty_ff)))
      else $error("frame_length disagrees with kind or empty_frame");

   // no store write while a readout is running
   a_no_write_in_drain: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_DRAIN |-> !cmd_we && !par_we)
      else $error("store written during readout");
`endif

endmodule

// ===== rtl/dcfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dcfr_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 62,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
